/* sv/mrfd_pkg.sv */
// ----------------------------------------------------------------------------
// mrfd_pkg
// Shared constants, types and the CRC-16/Modbus byte step for the meter
// response frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mrfd_pkg;

    // Length of a complete read-input-registers reply, CRC bytes included.
    localparam int unsigned FRAME_BYTES = 25;
    localparam int unsigned COUNT_W     = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Input item kinds carried on the input tuser bit.
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    localparam logic [COUNT_W-1:0] LAST_INDEX = COUNT_W'(FRAME_BYTES - 1);

    // Width of the packed result tdata, padded to whole bytes.
    localparam int unsigned RES_BITS  = 5 + 16 + 32 + 32 + 32 + 16 + 16 + 16;
    localparam int unsigned RES_BYTES = (RES_BITS + 7) / 8;
    localparam int unsigned RES_W     = RES_BYTES * 8;

    typedef struct packed {
        logic [15:0]        alarm_raw;
        logic [15:0]        pf_raw;
        logic [15:0]        frequency_raw;
        logic [31:0]        energy_raw;
        logic [31:0]        power_raw;
        logic [31:0]        current_raw;
        logic [15:0]        voltage_raw;
        logic [COUNT_W-1:0] bytes_seen;
        logic               frame_ok;
    } mrfd_result_t;

    // One byte of reflected CRC-16/Modbus: eight shift-and-xor steps.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/mrfd_core.sv */
// ----------------------------------------------------------------------------
// mrfd_core
// Frame state of the decoder: byte count, delayed CRC, field capture and the
// end-of-frame decision, updated once per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfd_core
    import mrfd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         step,
    input  wire logic         action,
    input  wire logic [7:0]   rx_byte,
    output logic              res_valid,
    output mrfd_result_t      res
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] tail_reg, tail_next;
    logic [15:0] volt_reg, volt_next;
    logic [31:0] curr_reg, curr_next;
    logic [31:0] pwr_reg, pwr_next;
    logic [31:0] nrg_reg, nrg_next;
    logic [15:0] freq_reg, freq_next;
    logic [15:0] pf_reg, pf_next;
    logic [15:0] alarm_reg, alarm_next;
    logic        frame_end;
    logic        crc_match;
    logic        clear;

    always_comb begin
        // The CRC runs two bytes behind the input so the trailing CRC bytes
        // never enter it.
        crc_next   = (count_reg >= COUNT_W'(2)) ? crc_feed(crc_reg, tail_reg[15:8]) : crc_reg;
        tail_next  = {tail_reg[7:0], rx_byte};
        count_next = count_reg + COUNT_W'(1);
        volt_next  = volt_reg;
        curr_next  = curr_reg;
        pwr_next   = pwr_reg;
        nrg_next   = nrg_reg;
        freq_next  = freq_reg;
        pf_next    = pf_reg;
        alarm_next = alarm_reg;

        // Register data is big-endian per word, 32-bit values low word first.
        case (count_reg)
            5'd3:  volt_next[15:8]   = rx_byte;
            5'd4:  volt_next[7:0]    = rx_byte;
            5'd5:  curr_next[15:8]   = rx_byte;
            5'd6:  curr_next[7:0]    = rx_byte;
            5'd7:  curr_next[31:24]  = rx_byte;
            5'd8:  curr_next[23:16]  = rx_byte;
            5'd9:  pwr_next[15:8]    = rx_byte;
            5'd10: pwr_next[7:0]     = rx_byte;
            5'd11: pwr_next[31:24]   = rx_byte;
            5'd12: pwr_next[23:16]   = rx_byte;
            5'd13: nrg_next[15:8]    = rx_byte;
            5'd14: nrg_next[7:0]     = rx_byte;
            5'd15: nrg_next[31:24]   = rx_byte;
            5'd16: nrg_next[23:16]   = rx_byte;
            5'd17: freq_next[15:8]   = rx_byte;
            5'd18: freq_next[7:0]    = rx_byte;
            5'd19: pf_next[15:8]     = rx_byte;
            5'd20: pf_next[7:0]      = rx_byte;
            5'd21: alarm_next[15:8]  = rx_byte;
            5'd22: alarm_next[7:0]   = rx_byte;
            default: ;
        endcase

        frame_end = (count_reg == LAST_INDEX);
        // The received CRC arrives low byte first.
        crc_match = ({tail_next[7:0], tail_next[15:8]} == crc_next);

        res = '0;
        res_valid = 1'b0;
        if (step) begin
            if (action == ACT_TIMEOUT) begin
                res_valid      = 1'b1;
                res.bytes_seen = count_reg;
            end else if (frame_end) begin
                res_valid      = 1'b1;
                res.bytes_seen = count_next;
                if (crc_match) begin
                    res.frame_ok      = 1'b1;
                    res.voltage_raw   = volt_reg;
                    res.current_raw   = curr_reg;
                    res.power_raw     = pwr_reg;
                    res.energy_raw    = nrg_reg;
                    res.frequency_raw = freq_reg;
                    res.pf_raw        = pf_reg;
                    res.alarm_raw     = alarm_reg;
                end
            end
        end
        clear = res_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && clear)) begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
            tail_reg  <= '0;
            volt_reg  <= '0;
            curr_reg  <= '0;
            pwr_reg   <= '0;
            nrg_reg   <= '0;
            freq_reg  <= '0;
            pf_reg    <= '0;
            alarm_reg <= '0;
        end else if (step) begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            tail_reg  <= tail_next;
            volt_reg  <= volt_next;
            curr_reg  <= curr_next;
            pwr_reg   <= pwr_next;
            nrg_reg   <= nrg_next;
            freq_reg  <= freq_next;
            pf_reg    <= pf_next;
            alarm_reg <= alarm_next;
        end
    end

endmodule

`default_nettype wire

/* sv/meter_response_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// meter_response_frame_decoder_top
// Decodes a 25-byte Modbus RTU read-input-registers reply from a power meter
// and returns the raw measurement words with a CRC-checked ok flag.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata (low bit first)                         tuser
// s_*       in   rx_byte[7:0]                                  action
// m_*       out  bytes_seen, voltage, current, power, energy,  frame_ok
//                frequency, pf, alarm, 3 zero pad bits
//
// One word is taken per clock unless a waiting result stalls the input. A word
// is first held in the input register; when the decoder steps, one pass
// through the CRC byte step and capture logic updates the frame state and, on
// the 25th byte or a timeout, loads the result register that drives m_tvalid.
// Synchronous active-low reset clears the frame state and both valid flags.
// When m_tready is low with a result waiting, one more input word is held in
// the input register and s_tready drops after it.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_response_frame_decoder_top
    import mrfd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] rx_byte
    input  wire logic             s_tuser,   // [0] action: 0 byte, 1 timeout

    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [RES_W-1:0]      m_tdata,   // bytes_seen, voltage_raw, current_raw,
                                             // power_raw, energy_raw, frequency_raw,
                                             // pf_raw, alarm_raw, zero pad
    output logic                  m_tuser    // [0] frame_ok
);

    logic          in_valid_reg;
    logic          in_action_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    mrfd_result_t  out_res_reg;
    logic          advance;
    logic          res_valid;
    mrfd_result_t  res;

    // The decoder steps on a held input word whenever the result register is free
    // or emptying, so a byte that ends a frame always has a place to put its result.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    mrfd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .action    (in_action_reg),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.frame_ok;
    assign m_tdata  = {(RES_W - RES_BITS)'(0), out_res_reg.alarm_raw, out_res_reg.pf_raw,
                       out_res_reg.frequency_raw, out_res_reg.energy_raw,
                       out_res_reg.power_raw, out_res_reg.current_raw,
                       out_res_reg.voltage_raw, out_res_reg.bytes_seen};

endmodule

`default_nettype wire

/* sv/mrfd_checker.sv */
// ----------------------------------------------------------------------------
// mrfd_checker
// Port-level checks on the decoder result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfd_checker
    import mrfd_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [RES_W-1:0] m_tdata,
    input wire logic             m_tuser
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A good frame always counts the full frame length.
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[4:0] == COUNT_W'(FRAME_BYTES))
        else $error("good frame with wrong byte count");

    // A failed frame reports no measurement data.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[RES_BITS-1:5] == '0)
        else $error("failed frame carries measurement data");

    // The byte count never passes the frame length.
    a_len_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[4:0] <= COUNT_W'(FRAME_BYTES))
        else $error("byte count beyond frame length");

endmodule

bind meter_response_frame_decoder_top mrfd_checker u_mrfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
